[hdl/tsp_pkg.sv]
// Package for the timer slot pool: sizes, request codes and control types.
`timescale 1ns / 1ps
`default_nettype none

package tsp_pkg;

  // Pool size and field widths
  localparam int NumSlots = 8;
  localparam int SlotIdxW = (NumSlots > 1) ? $clog2(NumSlots) : 1;
  localparam int IdW      = 8;
  localparam int TimeW    = 32;
  localparam int KindW    = 2;

  // Request kinds
  typedef enum logic [KindW-1:0] {
    REQ_TICK    = 2'd0,
    REQ_CREATE  = 2'd1,
    REQ_CHECK   = 2'd2,
    REQ_DESTROY = 2'd3
  } req_kind_e;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the incoming request word
    logic exec;     // apply the request to the slot state
    logic load;     // load the result word into the output register
  } tsp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_busy; // output register holds a word that is not taken now
  } tsp_sts_t;

endpackage

`default_nettype wire

[hdl/tsp_req_if.sv]
// Request and response channel interfaces of the timer slot pool.
`timescale 1ns / 1ps
`default_nettype none

interface tsp_req_if;
  import tsp_pkg::*;

  logic                valid;
  logic                ready;
  logic [KindW-1:0]    req_type;
  logic [TimeW-1:0]    timeout_ms;
  logic [IdW-1:0]      timer_id;

  modport source (output valid, output req_type, output timeout_ms, output timer_id,
                  input ready);
  modport sink   (input valid, input req_type, input timeout_ms, input timer_id,
                  output ready);
endinterface

interface tsp_rsp_if;
  import tsp_pkg::*;

  logic                valid;
  logic                ready;
  logic [IdW-1:0]      created_id;
  logic                is_expired;
  logic                any_waiting;
  logic [TimeW-1:0]    timestamp;

  modport source (output valid, output created_id, output is_expired,
                  output any_waiting, output timestamp, input ready);
  modport sink   (input valid, input created_id, input is_expired,
                  input any_waiting, input timestamp, output ready);
endinterface

`default_nettype wire

[hdl/tsp_ctrl.sv]
// Sequencer of the timer slot pool: capture, execute, result load.
`timescale 1ns / 1ps
`default_nettype none

module tsp_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              req_valid_i,
  output logic                   req_ready_o,
  input  wire tsp_pkg::tsp_sts_t sts_i,
  output tsp_pkg::tsp_cmd_t      cmd_o
);
  import tsp_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_EVAL
  } state_e;

  state_e state_q;
  logic   ready_q;

  // State and registered ready
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ready_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (ready_q && req_valid_i) begin
            state_q <= ST_EXEC;
            ready_q <= 1'b0;
          end else begin
            ready_q <= 1'b1;
          end
        end
        ST_EXEC: begin
          state_q <= ST_EVAL;
        end
        ST_EVAL: begin
          if (!sts_i.out_busy) begin
            state_q <= ST_IDLE;
            ready_q <= 1'b1;
          end
        end
        default: begin
          state_q <= ST_IDLE;
          ready_q <= 1'b0;
        end
      endcase
    end
  end

  // Commands
  assign req_ready_o   = ready_q;
  assign cmd_o.capture = ready_q && req_valid_i;
  assign cmd_o.exec    = (state_q == ST_EXEC);
  assign cmd_o.load    = (state_q == ST_EVAL) && !sts_i.out_busy;

endmodule

`default_nettype wire

[hdl/tsp_dpath.sv]
// Datapath of the timer slot pool: tick counter, slot registers, result register.
`timescale 1ns / 1ps
`default_nettype none

module tsp_dpath (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire tsp_pkg::tsp_cmd_t         cmd_i,
  output tsp_pkg::tsp_sts_t              sts_o,
  input  wire logic [tsp_pkg::KindW-1:0] req_type_i,
  input  wire logic [tsp_pkg::TimeW-1:0] timeout_ms_i,
  input  wire logic [tsp_pkg::IdW-1:0]   timer_id_i,
  input  wire logic                      rsp_ready_i,
  output logic                           rsp_valid_o,
  output logic [tsp_pkg::IdW-1:0]        created_id_o,
  output logic                           is_expired_o,
  output logic                           any_waiting_o,
  output logic [tsp_pkg::TimeW-1:0]      timestamp_o
);
  import tsp_pkg::*;

  // Captured request word
  req_kind_e          kind_q;
  logic [TimeW-1:0]   tmo_q;
  logic [IdW-1:0]     id_q;

  // Pool state
  logic [TimeW-1:0]   tick_q;
  logic [NumSlots-1:0] used_q;
  logic [NumSlots-1:0] exp_q;
  logic [TimeW-1:0]   slot_tmo_q   [NumSlots];
  logic [TimeW-1:0]   slot_start_q [NumSlots];

  // Per-request results
  logic [IdW-1:0]     created_q;
  logic               expired_q;

  // Output register
  logic               rsp_valid_q;
  logic [IdW-1:0]     rsp_created_q;
  logic               rsp_expired_q;
  logic               rsp_waiting_q;
  logic [TimeW-1:0]   rsp_stamp_q;

  // Lowest free slot
  logic               free_found;
  logic [SlotIdxW-1:0] free_idx;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NumSlots - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_found = 1'b1;
        free_idx   = SlotIdxW'(i);
      end
    end
  end

  // Id decode for check and destroy
  logic               id_ok;
  logic [IdW-1:0]     id_m1;
  logic [SlotIdxW-1:0] sel;
  logic [TimeW-1:0]   sel_elapsed;
  logic               sel_exp_next;

  assign id_ok        = (id_q != '0) && (id_q <= IdW'(NumSlots));
  assign id_m1        = id_q - IdW'(1);
  assign sel          = id_m1[SlotIdxW-1:0];
  assign sel_elapsed  = tick_q - slot_start_q[sel];
  assign sel_exp_next = exp_q[sel] || (sel_elapsed >= slot_tmo_q[sel]);

  // Waiting flag over all slot lanes, from the updated state
  logic [NumSlots-1:0] lane_wait;
  logic [TimeW-1:0]    lane_elapsed [NumSlots];

  always_comb begin
    for (int i = 0; i < NumSlots; i++) begin
      lane_elapsed[i] = tick_q - slot_start_q[i];
      lane_wait[i]    = used_q[i] && !exp_q[i] && (lane_elapsed[i] < slot_tmo_q[i]);
    end
  end

  // Request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= req_kind_e'(req_type_i);
      tmo_q  <= timeout_ms_i;
      id_q   <= timer_id_i;
    end
  end

  // Slot payload: written by create only; unused slots are never read
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && kind_q == REQ_CREATE && free_found) begin
      slot_tmo_q[free_idx]   <= tmo_q;
      slot_start_q[free_idx] <= tick_q;
    end
  end

  // Control state of the pool and per-request results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q    <= '0;
      used_q    <= '0;
      exp_q     <= '0;
      created_q <= '0;
      expired_q <= 1'b0;
    end else if (cmd_i.exec) begin
      created_q <= '0;
      expired_q <= 1'b0;
      case (kind_q)
        REQ_TICK: begin
          tick_q <= tick_q + TimeW'(1);
        end
        REQ_CREATE: begin
          if (free_found) begin
            used_q[free_idx] <= 1'b1;
            exp_q[free_idx]  <= 1'b0;
            created_q        <= IdW'(free_idx) + IdW'(1);
          end
        end
        REQ_CHECK: begin
          expired_q <= 1'b1;
          if (id_ok && used_q[sel]) begin
            exp_q[sel] <= sel_exp_next;
            expired_q  <= sel_exp_next;
          end
        end
        REQ_DESTROY: begin
          if (id_ok) begin
            used_q[sel] <= 1'b0;
            exp_q[sel]  <= 1'b0;
          end
        end
        default: begin
          tick_q <= tick_q;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rsp_created_q <= created_q;
      rsp_expired_q <= expired_q;
      rsp_waiting_q <= |lane_wait;
      rsp_stamp_q   <= tick_q;
    end
  end

  assign sts_o.out_busy = rsp_valid_q && !rsp_ready_i;
  assign rsp_valid_o    = rsp_valid_q;
  assign created_id_o   = rsp_created_q;
  assign is_expired_o   = rsp_expired_q;
  assign any_waiting_o  = rsp_waiting_q;
  assign timestamp_o    = rsp_stamp_q;

endmodule

`default_nettype wire

[hdl/timer_slot_pool_unit.sv]
// Top level of the timer slot pool: sequencer, datapath and channel hookup.
//
// A pool of NumSlots one-shot timers run off a wrapping 32-bit tick count.
// Request channel req_i (valid/ready) carries one word: req_type (tick,
// create, check, destroy), timeout_ms and timer_id. Response channel rsp_o
// (valid/ready) returns one word per request: created_id, is_expired,
// any_waiting and timestamp, all taken after the request is applied.
// Each request passes three steps: capture, execute against the slot
// registers, then evaluate the any_waiting lanes and load the output
// register. A new request is accepted only after the current one has
// loaded its result and the sequencer is back in idle. A result
// waiting in the output register does not block acceptance of the
// next request; only the load of the following result waits until
// the receiver takes the held word.
// Reset clears the tick count, all slot used and expired flags and the
// output valid; the registered ready rises in the cycle after release.
`timescale 1ns / 1ps
`default_nettype none

module timer_slot_pool_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tsp_req_if.sink   req_i,
  tsp_rsp_if.source rsp_o
);
  import tsp_pkg::*;

  tsp_cmd_t cmd;
  tsp_sts_t sts;

  tsp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tsp_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .req_type_i    (req_i.req_type),
    .timeout_ms_i  (req_i.timeout_ms),
    .timer_id_i    (req_i.timer_id),
    .rsp_ready_i   (rsp_o.ready),
    .rsp_valid_o   (rsp_o.valid),
    .created_id_o  (rsp_o.created_id),
    .is_expired_o  (rsp_o.is_expired),
    .any_waiting_o (rsp_o.any_waiting),
    .timestamp_o   (rsp_o.timestamp)
  );

  // One request in flight: no acceptance right after an accepted word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request accepted while previous one in flight");

  // A created id never exceeds the pool size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.created_id <= IdW'(NumSlots)))
    else $error("created id out of range");

  // A word carries either a created id or an expiry, never both
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> !(rsp_o.is_expired && (rsp_o.created_id != '0)))
    else $error("create and check results mixed in one word");

endmodule

`default_nettype wire
